// ===== sv/rpc_pkg.sv =====
// Shared types and constants of the relation property checker.
// Used by every module of the block; depends on nothing.
package rpc_pkg;

    localparam int DEF_MAX_ELEMENTS = 32;
    localparam int ELEM_W           = 6;
    localparam int SIZE_W           = 6;
    localparam int CLASS_W          = 2;

    localparam logic [CLASS_W-1:0] CLS_EQUIV   = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_PORDER  = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_NEITHER = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd1;

    typedef struct packed {
        logic reflexive;
        logic symmetric;
        logic antisymmetric;
        logic transitive;
    } t_props;

    function automatic logic [CLASS_W-1:0] classify(input t_props p);
        logic [CLASS_W-1:0] cls;
        if (p.reflexive && p.symmetric && p.transitive) begin
            cls = CLS_EQUIV;
        end else if (p.reflexive && p.antisymmetric && p.transitive) begin
            cls = CLS_PORDER;
        end else begin
            cls = CLS_NEITHER;
        end
        return cls;
    endfunction

endpackage

// ===== sv/rpc_row_mem.sv =====
// Row memory of the relation matrix: one write port, one registered read port.
// Rows carry valid bits so that one clear strobe empties the whole matrix. Uses rpc_pkg.
module rpc_row_mem #(
    parameter int   MAX_ELEMENTS = rpc_pkg::DEF_MAX_ELEMENTS,
    localparam int  IDX_W        = $clog2(MAX_ELEMENTS)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_clear,
    input  logic                    i_wr_en,
    input  logic [IDX_W-1:0]        i_wr_addr,
    input  logic [MAX_ELEMENTS-1:0] i_wr_data,
    input  logic                    i_rd_en,
    input  logic [IDX_W-1:0]        i_rd_addr,
    output logic [MAX_ELEMENTS-1:0] o_rd_data
);
    import rpc_pkg::*;

    logic [MAX_ELEMENTS-1:0] r_mem [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] r_valid;
    logic [MAX_ELEMENTS-1:0] r_rd_q;
    logic                    r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q <= r_mem[i_rd_addr];
        end
    end

    // A row that has not been written since the last clear reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_ok <= r_valid[i_rd_addr];
            end
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_q : '0;

endmodule

// ===== sv/rpc_eval.sv =====
// Evaluation sequencer: scans the row memory pair by pair and accumulates
// the four relation properties. Uses rpc_pkg and drives the read port of rpc_row_mem.
module rpc_eval #(
    parameter int  MAX_ELEMENTS = rpc_pkg::DEF_MAX_ELEMENTS,
    localparam int IDX_W        = $clog2(MAX_ELEMENTS),
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [CNT_W-1:0]        i_size,
    input  logic                    i_take,
    input  logic [MAX_ELEMENTS-1:0] i_rd_data,
    output logic                    o_rd_en,
    output logic [IDX_W-1:0]        o_rd_addr,
    output logic                    o_done,
    output rpc_pkg::t_props         o_props
);
    import rpc_pkg::*;

    typedef enum logic [4:0] {
        E_IDLE = 5'b00001,
        E_ROWI = 5'b00010,
        E_CAP  = 5'b00100,
        E_SCAN = 5'b01000,
        E_HOLD = 5'b10000
    } t_ev_state;

    t_ev_state               r_state, n_state;
    logic [IDX_W-1:0]        r_i, n_i;
    logic [IDX_W-1:0]        r_j, n_j;
    logic [MAX_ELEMENTS-1:0] r_row_i, n_row_i;
    t_props                  r_props, n_props;

    logic [MAX_ELEMENTS-1:0] ones;
    logic [MAX_ELEMENTS-1:0] col_mask;
    logic [CNT_W-1:0]        size_m1;
    logic [IDX_W-1:0]        last_idx;
    logic                    ij, ji;
    logic                    trans_hit;

    assign ones     = '1;
    assign col_mask = ~(ones << i_size);
    assign size_m1  = i_size - CNT_W'(1);
    assign last_idx = size_m1[IDX_W-1:0];

    assign ij        = r_row_i[r_j];
    assign ji        = i_rd_data[r_i];
    assign trans_hit = |(i_rd_data & col_mask & ~r_row_i);

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_row_i   = r_row_i;
        n_props   = r_props;
        o_rd_en   = 1'b0;
        o_rd_addr = r_i;
        case (r_state)
            E_IDLE: begin
                if (i_start) begin
                    n_props = '{reflexive: 1'b1, symmetric: 1'b1,
                                antisymmetric: 1'b1, transitive: 1'b1};
                    n_i     = '0;
                    n_state = (i_size == '0) ? E_HOLD : E_ROWI;
                end
            end
            E_ROWI: begin
                o_rd_en   = 1'b1;
                o_rd_addr = r_i;
                n_state   = E_CAP;
            end
            E_CAP: begin
                n_row_i   = i_rd_data;
                o_rd_en   = 1'b1;
                o_rd_addr = '0;
                n_j       = '0;
                n_state   = E_SCAN;
            end
            E_SCAN: begin
                // The word on the read port is row j; row i sits in r_row_i.
                if (r_i == r_j && !ij) begin
                    n_props.reflexive = 1'b0;
                end
                if (ij != ji) begin
                    n_props.symmetric = 1'b0;
                end
                if (ij && ji && r_i != r_j) begin
                    n_props.antisymmetric = 1'b0;
                end
                if (ij && trans_hit) begin
                    n_props.transitive = 1'b0;
                end
                if (r_j != last_idx) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_j + IDX_W'(1);
                    n_j       = r_j + IDX_W'(1);
                end else if (r_i == last_idx) begin
                    n_state = E_HOLD;
                end else begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = E_ROWI;
                end
            end
            E_HOLD: begin
                if (i_take) begin
                    n_state = E_IDLE;
                end
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row_i <= n_row_i;
        r_props <= n_props;
    end

    assign o_done  = (r_state == E_HOLD);
    assign o_props = r_props;

endmodule

// ===== sv/relation_property_checker_core.sv =====
// Top level of the relation property checker: load path, control and result register.
// Depends on rpc_pkg, rpc_row_mem and rpc_eval.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one word per pair of
//   one-based element numbers. A word with i_pair_present set stores its pair
//   in the matrix; a pair with an element of 0 or above the active size is dropped
//   and marks an index error. The word with i_last_pair set closes the set.
//   Pairs load at one word per cycle; a read-modify-write of the row memory
//   runs behind, with forwarding when two consecutive pairs hit the same row.
//   After the last word the input is held off while the evaluator walks the
//   matrix through the single read port of the row memory, over the active
//   size (set_size limited to MAX_ELEMENTS); the result word then appears on
//   o_out_valid / i_out_ready.
//   The matrix and the error flag are cleared when the result word is registered.
//   A stalled receiver does not block loading of the next set; only its
//   result waits until the previous one has been taken.
//   i_cfg_we writes set_size; write it only while the block is idle.
//   Reset (synchronous, active low) empties the matrix and sets set_size to 1.
module relation_property_checker_core #(
    parameter int MAX_ELEMENTS = rpc_pkg::DEF_MAX_ELEMENTS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [rpc_pkg::SIZE_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [rpc_pkg::ELEM_W-1:0]   i_first_element,
    input  logic [rpc_pkg::ELEM_W-1:0]   i_second_element,
    input  logic                         i_pair_present,
    input  logic                         i_last_pair,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_is_reflexive,
    output logic                         o_is_symmetric,
    output logic                         o_is_antisymmetric,
    output logic                         o_is_transitive,
    output logic [rpc_pkg::CLASS_W-1:0]  o_relation_class,
    output logic                         o_index_error
);
    import rpc_pkg::*;

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam logic [MAX_ELEMENTS-1:0] ROW_ONE = MAX_ELEMENTS'(1);

    typedef enum logic [2:0] {
        S_LOAD  = 3'b001,
        S_DRAIN = 3'b010,
        S_EVAL  = 3'b100
    } t_top_state;

    t_top_state r_state, n_state;
    logic [SIZE_W-1:0] r_set_size;
    logic              r_err;

    logic [CNT_W-1:0]  act_n;
    logic [ELEM_W:0]   size_ext, n_ext, a_ext, b_ext;
    logic              bad_pair;
    logic              in_acc;
    logic              out_free;
    logic              take;

    // Load pipeline
    logic                    ld_rd_en;
    logic [IDX_W-1:0]        ld_rd_addr;
    logic                    r_ld_valid;
    logic [IDX_W-1:0]        r_ld_row, r_ld_col;
    logic                    r_wr_valid;
    logic [IDX_W-1:0]        r_wr_addr;
    logic [MAX_ELEMENTS-1:0] r_wr_data;
    logic [MAX_ELEMENTS-1:0] wr_data;
    logic                    fwd;

    // Memory and evaluator connections
    logic                    mem_rd_en;
    logic [IDX_W-1:0]        mem_rd_addr;
    logic [MAX_ELEMENTS-1:0] mem_rd_data;
    logic                    ev_rd_en;
    logic [IDX_W-1:0]        ev_rd_addr;
    logic                    ev_start;
    logic                    ev_done;
    t_props                  ev_props;

    // Output register
    logic               r_out_valid;
    t_props             r_out_props;
    logic [CLASS_W-1:0] r_out_class;
    logic               r_out_err;

    assign size_ext = {1'b0, r_set_size};
    assign act_n    = (size_ext > (ELEM_W+1)'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS)
                                                              : CNT_W'(r_set_size);
    assign n_ext    = (ELEM_W+1)'(act_n);
    assign a_ext    = {1'b0, i_first_element};
    assign b_ext    = {1'b0, i_second_element};
    assign bad_pair = (i_first_element == '0) || (i_second_element == '0) ||
                      (a_ext > n_ext) || (b_ext > n_ext);

    assign o_in_ready = (r_state == S_LOAD);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign take       = (r_state == S_EVAL) && ev_done && out_free;
    assign ev_start   = (r_state == S_DRAIN);

    assign ld_rd_en   = in_acc && i_pair_present && !bad_pair;
    assign ld_rd_addr = IDX_W'(i_first_element - ELEM_W'(1));

    // The row written in the previous cycle is not yet visible on the read port.
    assign fwd     = r_wr_valid && (r_wr_addr == r_ld_row);
    assign wr_data = (fwd ? r_wr_data : mem_rd_data) | (ROW_ONE << r_ld_col);

    assign mem_rd_en   = ld_rd_en || ev_rd_en;
    assign mem_rd_addr = ev_rd_en ? ev_rd_addr : ld_rd_addr;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (in_acc && i_last_pair) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (take) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_set_size  <= SIZE_RESET;
            r_err       <= 1'b0;
            r_ld_valid  <= 1'b0;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ld_valid <= ld_rd_en;
            r_wr_valid <= r_ld_valid;
            if (i_cfg_we) begin
                r_set_size <= i_cfg_data;
            end
            if (take) begin
                r_err <= 1'b0;
            end else if (in_acc && i_pair_present && bad_pair) begin
                r_err <= 1'b1;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_rd_en) begin
            r_ld_row <= ld_rd_addr;
            r_ld_col <= IDX_W'(i_second_element - ELEM_W'(1));
        end
        r_wr_addr <= r_ld_row;
        r_wr_data <= wr_data;
        if (take) begin
            r_out_props <= ev_props;
            r_out_class <= classify(ev_props);
            r_out_err   <= r_err;
        end
    end

    rpc_row_mem #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (take),
        .i_wr_en   (r_ld_valid),
        .i_wr_addr (r_ld_row),
        .i_wr_data (wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    rpc_eval #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (ev_start),
        .i_size    (act_n),
        .i_take    (take),
        .i_rd_data (mem_rd_data),
        .o_rd_en   (ev_rd_en),
        .o_rd_addr (ev_rd_addr),
        .o_done    (ev_done),
        .o_props   (ev_props)
    );

    assign o_out_valid        = r_out_valid;
    assign o_is_reflexive     = r_out_props.reflexive;
    assign o_is_symmetric     = r_out_props.symmetric;
    assign o_is_antisymmetric = r_out_props.antisymmetric;
    assign o_is_transitive    = r_out_props.transitive;
    assign o_relation_class   = r_out_class;
    assign o_index_error      = r_out_err;

endmodule

// ===== sv/rpc_checker.sv =====
// Port-level assertions for the relation property checker, bound to the top level.
// Depends on rpc_pkg and relation_property_checker_core.
module rpc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         o_in_ready,
    input logic                         i_last_pair,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic                         o_is_reflexive,
    input logic                         o_is_symmetric,
    input logic                         o_is_antisymmetric,
    input logic                         o_is_transitive,
    input logic [rpc_pkg::CLASS_W-1:0]  o_relation_class,
    input logic                         o_index_error
);
    import rpc_pkg::*;

    // Evaluation after the closing word always holds the input off.
    a_stall_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_last_pair |=> !o_in_ready)
        else $error("input accepted straight after the closing word");

    a_equiv_props: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_relation_class == CLS_EQUIV |->
            o_is_reflexive && o_is_symmetric && o_is_transitive)
        else $error("equivalence reported without its properties");

    // A partial order that were also symmetric would have been an equivalence.
    a_porder_props: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_relation_class == CLS_PORDER |->
            o_is_reflexive && o_is_antisymmetric && o_is_transitive && !o_is_symmetric)
        else $error("partial order reported with inconsistent properties");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_relation_class) &&
            $stable(o_index_error) && $stable(o_is_transitive))
        else $error("result word changed while stalled");

endmodule

bind relation_property_checker_core rpc_checker u_rpc_checker (.*);
